/* sv/epbc_pkg.sv */
package epbc_pkg;

  // Field widths of the command and result words.
  localparam int MODE_W      = 3;
  localparam int ADDR_W      = 12;
  localparam int DATA_W      = 8;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  // Default geometry of the array.
  localparam int DEF_PAGE_BYTES = 32;
  localparam int DEF_PAGE_COUNT = 128;

  // Fraction bits of the reciprocals used to split an address into page and byte.
  localparam int DIV_SHIFT = 24;

  localparam logic [DATA_W-1:0] ERASED_BYTE = 8'hFF;

  typedef enum logic [MODE_W-1:0] {
    MODE_READ        = 3'd0,
    MODE_LOAD        = 3'd1,
    MODE_FLUSH       = 3'd2,
    MODE_ERASE_WRITE = 3'd3,
    MODE_ERASE_PAGE  = 3'd4,
    MODE_SPLIT_WRITE = 3'd5,
    MODE_ERASE_ALL   = 3'd6
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_Q,
    ST_DIV_R,
    ST_PAGE_Q,
    ST_PAGE_R,
    ST_EXEC,
    ST_RMW,
    ST_SWEEP,
    ST_FIN
  } state_t;

endpackage

/* sv/epbc_ram.sv */
module epbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/eeprom_page_buffer_controller.sv */
// Each command passes the address decode states, then read and load take a read-modify-write
// step, erase-write and split write sweep the whole page, and the other modes go straight to finish.
// A new command word is taken only once the last one is through; in_tready returns in the cycle the
// result appears and the next word is taken at the end of that cycle. A waiting result does not
// block that, and the next command then holds in its last step until the output is free.
// Reset (rst_n low, synchronous) empties the page buffer and marks every page erased at once.
module eeprom_page_buffer_controller #(
  parameter int PAGE_BYTES = epbc_pkg::DEF_PAGE_BYTES,
  parameter int PAGE_COUNT = epbc_pkg::DEF_PAGE_COUNT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // Fields from bit 0: mode[2:0], address[14:3], data[22:15], zero fill.
  input  logic [epbc_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // Fields from bit 0: read_data[7:0], buffer_loaded[8], zero fill.
  output logic [epbc_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  import epbc_pkg::*;

  localparam int ARRAY_BYTES = PAGE_BYTES * PAGE_COUNT;
  localparam int FLAT_W      = $clog2(ARRAY_BYTES);
  localparam int IDX_W       = $clog2(PAGE_BYTES);
  localparam int PAGE_W      = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

  // Reciprocals for splitting an address by constant divisors; the truncated
  // quotient is at most one short, and one compare and subtract corrects it.
  localparam logic [DIV_SHIFT-1:0] RECIP_AB = DIV_SHIFT'((1 << DIV_SHIFT) / ARRAY_BYTES);
  localparam logic [DIV_SHIFT-1:0] RECIP_PB = DIV_SHIFT'((1 << DIV_SHIFT) / PAGE_BYTES);

  state_t state_r, state_nxt;

  // Command word held for the whole operation.
  mode_t             mode_r, mode_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;

  // Address decode: flat array index, then page number and byte within the page.
  logic [ADDR_W+DIV_SHIFT-1:0] prod_ab;
  logic [FLAT_W+DIV_SHIFT-1:0] prod_pb;
  logic [ADDR_W-1:0]           rem_ab;
  logic [FLAT_W-1:0]           rem_pb;
  logic [ADDR_W-1:0]           q_ab_r, q_ab_nxt;
  logic [FLAT_W-1:0]           flat_r, flat_nxt;
  logic [PAGE_W-1:0]           q_pb_r, q_pb_nxt;
  logic [IDX_W-1:0]            idx_r, idx_nxt;
  logic [PAGE_W-1:0]           page_r, page_nxt;
  logic [FLAT_W-1:0]           base_r, base_nxt;

  // Buffer marks and per-page written flags; a page whose flag is clear reads erased.
  logic [PAGE_BYTES-1:0] marks_r, marks_nxt;
  logic [PAGE_COUNT-1:0] pv_r, pv_nxt;

  // Page sweep: read of byte cnt_r in flight, write of byte pend_idx_r in the cycle after its read.
  logic [IDX_W:0]   cnt_r, cnt_nxt;
  logic             pend_r, pend_nxt;
  logic [IDX_W-1:0] pend_idx_r, pend_idx_nxt;
  logic             sweep_issue;

  logic [DATA_W-1:0] res_rd_r, res_rd_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [DATA_W-1:0] out_rd_r, out_rd_nxt;
  logic              out_ld_r, out_ld_nxt;
  logic              out_free;

  // Memory ports.
  logic              cell_we, cell_re;
  logic [FLAT_W-1:0] cell_waddr, cell_raddr;
  logic [DATA_W-1:0] cell_wdata, cell_rdata;
  logic              buf_we, buf_re;
  logic [IDX_W-1:0]  buf_waddr, buf_raddr;
  logic [DATA_W-1:0] buf_wdata, buf_rdata;

  // Byte values used by the read-modify-write paths.
  logic [DATA_W-1:0] old_b, buf_b, new_b, load_b;
  logic              pend_mark;

  epbc_ram #(.WIDTH(DATA_W), .DEPTH(ARRAY_BYTES)) u_cells (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .re    (cell_re),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  epbc_ram #(.WIDTH(DATA_W), .DEPTH(PAGE_BYTES)) u_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_waddr),
    .wdata (buf_wdata),
    .re    (buf_re),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_TDATA_W-DATA_W-1){1'b0}}, out_ld_r, out_rd_r};
  assign out_free   = !out_tvalid_r || out_tready;

  assign prod_ab = addr_r * RECIP_AB;
  assign prod_pb = flat_r * RECIP_PB;
  assign rem_ab  = addr_r - ADDR_W'(q_ab_r * ARRAY_BYTES);
  assign rem_pb  = flat_r - FLAT_W'(q_pb_r * PAGE_BYTES);

  assign sweep_issue = (cnt_r < (IDX_W+1)'(PAGE_BYTES));

  // A byte not yet programmed in a page that was never written reads erased;
  // an unmarked buffer byte reads erased.
  assign old_b     = pv_r[page_r] ? cell_rdata : ERASED_BYTE;
  assign pend_mark = marks_r[pend_idx_r];
  assign buf_b     = pend_mark ? buf_rdata : ERASED_BYTE;
  assign load_b    = (marks_r[idx_r] ? buf_rdata : ERASED_BYTE) & data_r;

  always_comb begin
    if (!pend_mark) begin
      new_b = old_b;
    end else if (mode_r == MODE_SPLIT_WRITE) begin
      new_b = old_b & buf_b;
    end else begin
      new_b = buf_b;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_DIV_Q;
        end
      end
      ST_DIV_Q:  state_nxt = ST_DIV_R;
      ST_DIV_R:  state_nxt = ST_PAGE_Q;
      ST_PAGE_Q: state_nxt = ST_PAGE_R;
      ST_PAGE_R: state_nxt = ST_EXEC;
      ST_EXEC: begin
        unique case (mode_r) inside
          MODE_READ, MODE_LOAD:               state_nxt = ST_RMW;
          MODE_ERASE_WRITE, MODE_SPLIT_WRITE: state_nxt = ST_SWEEP;
          default:                            state_nxt = ST_FIN;
        endcase
      end
      ST_RMW: state_nxt = ST_FIN;
      ST_SWEEP: begin
        if (!sweep_issue && !pend_r) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, memory controls and outputs.
  always_comb begin
    mode_nxt       = mode_r;
    addr_nxt       = addr_r;
    data_nxt       = data_r;
    q_ab_nxt       = q_ab_r;
    flat_nxt       = flat_r;
    q_pb_nxt       = q_pb_r;
    idx_nxt        = idx_r;
    page_nxt       = page_r;
    base_nxt       = base_r;
    marks_nxt      = marks_r;
    pv_nxt         = pv_r;
    cnt_nxt        = cnt_r;
    pend_nxt       = pend_r;
    pend_idx_nxt   = pend_idx_r;
    res_rd_nxt     = res_rd_r;
    out_tvalid_nxt = out_tvalid_r;
    out_rd_nxt     = out_rd_r;
    out_ld_nxt     = out_ld_r;
    cell_we        = 1'b0;
    cell_waddr     = base_r + FLAT_W'(pend_idx_r);
    cell_wdata     = new_b;
    cell_re        = 1'b0;
    cell_raddr     = flat_r;
    buf_we         = 1'b0;
    buf_waddr      = idx_r;
    buf_wdata      = load_b;
    buf_re         = 1'b0;
    buf_raddr      = idx_r;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          mode_nxt = mode_t'(in_tdata[MODE_W-1:0]);
          addr_nxt = in_tdata[MODE_W +: ADDR_W];
          data_nxt = in_tdata[MODE_W+ADDR_W +: DATA_W];
        end
      end
      ST_DIV_Q: begin
        q_ab_nxt = prod_ab[ADDR_W+DIV_SHIFT-1:DIV_SHIFT];
      end
      ST_DIV_R: begin
        if (rem_ab >= ARRAY_BYTES) begin
          flat_nxt = FLAT_W'(rem_ab - ARRAY_BYTES);
        end else begin
          flat_nxt = FLAT_W'(rem_ab);
        end
      end
      ST_PAGE_Q: begin
        q_pb_nxt = PAGE_W'(prod_pb[FLAT_W+DIV_SHIFT-1:DIV_SHIFT]);
      end
      ST_PAGE_R: begin
        if (rem_pb >= PAGE_BYTES) begin
          idx_nxt  = IDX_W'(rem_pb - PAGE_BYTES);
          page_nxt = q_pb_r + 1'b1;
          base_nxt = flat_r - FLAT_W'(rem_pb - PAGE_BYTES);
        end else begin
          idx_nxt  = IDX_W'(rem_pb);
          page_nxt = q_pb_r;
          base_nxt = flat_r - rem_pb;
        end
      end
      ST_EXEC: begin
        res_rd_nxt   = '0;
        cnt_nxt      = '0;
        pend_nxt     = 1'b0;
        unique case (mode_r) inside
          MODE_READ: begin
            cell_re = 1'b1;
          end
          MODE_LOAD: begin
            buf_re = 1'b1;
          end
          MODE_FLUSH: begin
            marks_nxt = '0;
          end
          MODE_ERASE_PAGE: begin
            pv_nxt[page_r] = 1'b0;
            marks_nxt      = '0;
          end
          MODE_ERASE_ALL: begin
            pv_nxt    = '0;
            marks_nxt = '0;
          end
          default: begin
          end
        endcase
      end
      ST_RMW: begin
        if (mode_r == MODE_READ) begin
          res_rd_nxt = old_b;
        end else begin
          buf_we          = 1'b1;
          marks_nxt[idx_r] = 1'b1;
        end
      end
      ST_SWEEP: begin
        if (sweep_issue) begin
          cell_re      = 1'b1;
          cell_raddr   = base_r + FLAT_W'(cnt_r[IDX_W-1:0]);
          buf_re       = 1'b1;
          buf_raddr    = cnt_r[IDX_W-1:0];
          pend_idx_nxt = cnt_r[IDX_W-1:0];
          cnt_nxt      = cnt_r + 1'b1;
        end
        pend_nxt = sweep_issue;
        if (pend_r) begin
          cell_we = 1'b1;
        end
        if (!sweep_issue && !pend_r) begin
          // Every byte of the page now holds real data.
          pv_nxt[page_r] = 1'b1;
          marks_nxt      = '0;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_rd_nxt     = res_rd_r;
          out_ld_nxt     = |marks_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      marks_r      <= '0;
      pv_r         <= '0;
      cnt_r        <= '0;
      pend_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      marks_r      <= marks_nxt;
      pv_r         <= pv_nxt;
      cnt_r        <= cnt_nxt;
      pend_r       <= pend_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    addr_r     <= addr_nxt;
    data_r     <= data_nxt;
    q_ab_r     <= q_ab_nxt;
    flat_r     <= flat_nxt;
    q_pb_r     <= q_pb_nxt;
    idx_r      <= idx_nxt;
    page_r     <= page_nxt;
    base_r     <= base_nxt;
    pend_idx_r <= pend_idx_nxt;
    res_rd_r   <= res_rd_nxt;
    out_rd_r   <= out_rd_nxt;
    out_ld_r   <= out_ld_nxt;
  end

endmodule

/* sv/epbc_chk.sv */
module epbc_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [epbc_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [epbc_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import epbc_pkg::*;

  // Mode of the last accepted command; when the output rises from empty,
  // the word shown belongs to that command.
  logic [MODE_W-1:0] last_mode_r;

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      last_mode_r <= in_tdata[MODE_W-1:0];
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("command taken while the previous one is still in work");

  a_nonread_zero: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) && (last_mode_r != MODE_READ) |-> out_tdata[DATA_W-1:0] == '0)
    else $error("read data not zero for a command other than read");

  a_load_marks: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) && (last_mode_r == MODE_LOAD) |-> out_tdata[DATA_W])
    else $error("buffer not reported loaded after a load");

endmodule

bind eeprom_page_buffer_controller epbc_chk u_epbc_chk (.*);
